@@ rtl/tec_pkg.sv @@
// ----------------------------------------------------------------------------
// tec_pkg
// shared types and constants of the text encoding classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tec_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      CLASS_UTF8  = 2'd0,
      CLASS_SJIS  = 2'd1,
      CLASS_GBK   = 2'd2,
      CLASS_CP437 = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      U8_ASCII   = 3'd0,
      U8_CONT    = 3'd1,
      U8_LEAD2   = 3'd2,
      U8_LEAD3   = 3'd3,
      U8_LEAD4   = 3'd4,
      U8_INVALID = 3'd5
   } utf8_kind_type;

   typedef struct packed {
      utf8_kind_type utf8_kind;
      logic          sjis_lead;
      logic          sjis_trail;
      logic          gbk_lead;
      logic          gbk_trail;
      logic          final_byte;
   } token_type;

endpackage

`default_nettype wire

@@ rtl/text_encoding_classifier.sv @@
// ----------------------------------------------------------------------------
// text_encoding_classifier
// guesses the character encoding of a byte buffer streamed one byte a transfer
// ----------------------------------------------------------------------------
// req_* carries one byte of the buffer per transfer, req_tlast marks the last
// byte. For every buffer one result leaves on rsp_*: 0 utf-8, 1 shift-jis,
// 2 gbk, 3 cp437. Bytes without req_tlast give no result transfer.
// A classifier stage feeds a two-entry token queue, behind which a tracker
// keeps the utf-8, shift-jis and gbk state and holds the result register.
// Throughput is one byte per cycle while req_tready stays high; the tracker
// updates all state as it pops each token. The result passes through the
// token queue and then the result register on its way to rsp_*.
// When rsp_tready is low the result holds; further bytes still flow into the
// tracker until the next buffer's last byte, which waits for the result
// register, and then the queue fills and req_tready drops.
// Reset empties the queue, clears the result and returns all tracking state
// to its start values.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // final_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [1:0] encoding_class, [7:2] zero
);

   tec_pkg::token_type  in_token;
   tec_pkg::token_type  head_token;
   tec_pkg::class_type  result_class;
   logic                queue_full;
   logic                queue_not_empty;
   logic                queue_pop;

   tec_front u_front (
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .token      (in_token)
   );

   tec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_token (in_token),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .pop_token  (head_token)
   );

   tec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (queue_not_empty),
      .tok       (head_token),
      .tok_pop   (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_class (result_class),
      .rsp_ready (rsp_tready)
   );

   assign req_tready = !queue_full;
   assign rsp_tdata  = {6'b0, result_class};

endmodule

`default_nettype wire

@@ rtl/tec_front.sv @@
// ----------------------------------------------------------------------------
// tec_front
// byte classifier: turns each raw byte into a compact token of flags
// ----------------------------------------------------------------------------
`default_nettype none

module tec_front (
   input  wire logic [7:0]        data_byte,
   input  wire logic              final_byte,
   output tec_pkg::token_type     token
);

   always_comb begin
      token = '0;
      if (data_byte <= 8'h7F) begin
         token.utf8_kind = tec_pkg::U8_ASCII;
      end else if ((data_byte & 8'hC0) == 8'h80) begin
         token.utf8_kind = tec_pkg::U8_CONT;
      end else if ((data_byte & 8'hE0) == 8'hC0) begin
         token.utf8_kind = tec_pkg::U8_LEAD2;
      end else if ((data_byte & 8'hF0) == 8'hE0) begin
         token.utf8_kind = tec_pkg::U8_LEAD3;
      end else if ((data_byte & 8'hF8) == 8'hF0) begin
         token.utf8_kind = tec_pkg::U8_LEAD4;
      end else begin
         token.utf8_kind = tec_pkg::U8_INVALID;
      end
      token.sjis_lead  = (data_byte inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
      token.sjis_trail = (data_byte inside {[8'h40:8'h7E], [8'h80:8'hFC]});
      token.gbk_lead   = (data_byte inside {[8'h81:8'hFE]});
      token.gbk_trail  = (data_byte inside {[8'h40:8'h7E], [8'h80:8'hFE]});
      token.final_byte = final_byte;
   end

endmodule

`default_nettype wire

@@ rtl/tec_queue.sv @@
// ----------------------------------------------------------------------------
// tec_queue
// short token queue between the classifier and the state tracker
// ----------------------------------------------------------------------------
`default_nettype none

module tec_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tec_pkg::token_type push_token,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output tec_pkg::token_type      pop_token
);

   tec_pkg::token_type                   store [tec_pkg::QUEUE_DEPTH];
   logic [tec_pkg::QPTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tec_pkg::QPTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tec_pkg::QCNT_WIDTH-1:0]      count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == tec_pkg::QCNT_WIDTH'(tec_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_token = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tec_pkg::QPTR_WIDTH'(tec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tec_pkg::QPTR_WIDTH'(tec_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tec_back.sv @@
// ----------------------------------------------------------------------------
// tec_back
// running utf-8, shift-jis and gbk state, class decision and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tec_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tok_valid,
   input  wire tec_pkg::token_type tok,
   output logic                    tok_pop,
   output logic                    rsp_valid,
   output tec_pkg::class_type      rsp_class,
   input  wire logic               rsp_ready
);

   logic [1:0]          owed_ff, owed_in;
   logic                broken_ff, broken_in;
   logic                sjis_have_ff, sjis_have_in;
   logic                sjis_lead_ff, sjis_lead_in;
   logic                gbk_have_ff, gbk_have_in;
   logic                gbk_lead_ff, gbk_lead_in;
   tec_pkg::count_type  sjis_cnt_ff, sjis_cnt_in;
   tec_pkg::count_type  gbk_cnt_ff, gbk_cnt_in;
   logic                out_valid_ff, out_valid_in;
   tec_pkg::class_type  out_class_ff, out_class_in;
   logic                out_free;
   tec_pkg::count_type  sjis_next, gbk_next;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign tok_pop   = tok_valid && (!tok.final_byte || out_free);
   assign rsp_valid = out_valid_ff;
   assign rsp_class = out_class_ff;

   always_comb begin
      owed_in      = owed_ff;
      broken_in    = broken_ff;
      sjis_have_in = sjis_have_ff;
      sjis_lead_in = sjis_lead_ff;
      gbk_have_in  = gbk_have_ff;
      gbk_lead_in  = gbk_lead_ff;
      sjis_next    = sjis_cnt_ff;
      gbk_next     = gbk_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_class_in = out_class_ff;

      if (tok_pop) begin
         // utf-8 structure
         if (!broken_ff) begin
            if (owed_ff != 2'd0) begin
               if (tok.utf8_kind != tec_pkg::U8_CONT) begin
                  broken_in = 1'b1;
               end else begin
                  owed_in = owed_ff - 2'd1;
               end
            end else begin
               case (tok.utf8_kind)
                  tec_pkg::U8_ASCII: owed_in = 2'd0;
                  tec_pkg::U8_LEAD2: owed_in = 2'd1;
                  tec_pkg::U8_LEAD3: owed_in = 2'd2;
                  tec_pkg::U8_LEAD4: owed_in = 2'd3;
                  default:           broken_in = 1'b1;
               endcase
            end
         end

         // shift-jis pairing
         if (sjis_have_ff && sjis_lead_ff && tok.sjis_trail) begin
            if (sjis_cnt_ff != '1) begin
               sjis_next = sjis_cnt_ff + 1'b1;
            end
            sjis_have_in = 1'b0;
         end else begin
            sjis_have_in = 1'b1;
            sjis_lead_in = tok.sjis_lead;
         end

         // gbk pairing
         if (gbk_have_ff && gbk_lead_ff && tok.gbk_trail) begin
            if (gbk_cnt_ff != '1) begin
               gbk_next = gbk_cnt_ff + 1'b1;
            end
            gbk_have_in = 1'b0;
         end else begin
            gbk_have_in = 1'b1;
            gbk_lead_in = tok.gbk_lead;
         end
      end

      sjis_cnt_in = sjis_next;
      gbk_cnt_in  = gbk_next;

      if (tok_pop && tok.final_byte) begin
         out_valid_in = 1'b1;
         if (!broken_in && owed_in == 2'd0) begin
            out_class_in = tec_pkg::CLASS_UTF8;
         end else if (sjis_next > gbk_next) begin
            out_class_in = tec_pkg::CLASS_SJIS;
         end else if (gbk_next != '0) begin
            out_class_in = tec_pkg::CLASS_GBK;
         end else begin
            out_class_in = tec_pkg::CLASS_CP437;
         end
         owed_in      = 2'd0;
         broken_in    = 1'b0;
         sjis_have_in = 1'b0;
         sjis_lead_in = 1'b0;
         gbk_have_in  = 1'b0;
         gbk_lead_in  = 1'b0;
         sjis_cnt_in  = '0;
         gbk_cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff      <= 2'd0;
         broken_ff    <= 1'b0;
         sjis_have_ff <= 1'b0;
         sjis_lead_ff <= 1'b0;
         gbk_have_ff  <= 1'b0;
         gbk_lead_ff  <= 1'b0;
         sjis_cnt_ff  <= '0;
         gbk_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         owed_ff      <= owed_in;
         broken_ff    <= broken_in;
         sjis_have_ff <= sjis_have_in;
         sjis_lead_ff <= sjis_lead_in;
         gbk_have_ff  <= gbk_have_in;
         gbk_lead_ff  <= gbk_lead_in;
         sjis_cnt_ff  <= sjis_cnt_in;
         gbk_cnt_ff   <= gbk_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_class_ff <= out_class_in;
   end

endmodule

`default_nettype wire

@@ tb/tb_text_encoding_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_encoding_classifier
// self-checking testbench of the text encoding classifier
// ----------------------------------------------------------------------------
// Buffers are streamed byte by byte into req_*, with req_tlast on the final
// byte. A scoreboard follows every accepted byte with its own utf-8
// structure tracker and shift-jis / gbk pair counters. On each final byte it
// queues the expected class. Every rsp_* transfer is then checked against the
// oldest queued class.
// Stimulus is a short directed set of corner buffers, then about 1600 random
// bytes. These come as well-formed utf-8, broken or cut-off utf-8, shift-jis
// and gbk pair runs, and plain noise. Both sides idle at random, except for
// one calm stretch.
// ----------------------------------------------------------------------------

class encoding_scoreboard;

   logic [1:0]         owed;
   logic               utf8_broken;
   logic               sjis_has_held;
   logic [7:0]         sjis_held;
   logic               gbk_has_held;
   logic [7:0]         gbk_held;
   tec_pkg::count_type sjis_pairs;
   tec_pkg::count_type gbk_pairs;
   tec_pkg::class_type expected_q[$];
   int                 errors;

   function new();
      errors = 0;
      clear_state();
   endfunction

   function void clear_state();
      owed          = 2'd0;
      utf8_broken   = 1'b0;
      sjis_has_held = 1'b0;
      sjis_held     = 8'h00;
      gbk_has_held  = 1'b0;
      gbk_held      = 8'h00;
      sjis_pairs    = '0;
      gbk_pairs     = '0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void flag(input string msg);
      errors++;
      if (errors <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function void note_byte(input logic [7:0] b, input logic last);
      logic               sjis_lead;
      logic               sjis_trail;
      logic               gbk_lead;
      logic               gbk_trail;
      tec_pkg::class_type verdict;
      // utf-8 structure
      if (!utf8_broken) begin
         if (owed != 2'd0) begin
            if (b[7:6] != 2'b10)
               utf8_broken = 1'b1;
            else
               owed = owed - 2'd1;
         end else if (b[7] == 1'b0) begin
            owed = 2'd0;
         end else if (b[7:5] == 3'b110) begin
            owed = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            owed = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            owed = 2'd3;
         end else begin
            utf8_broken = 1'b1;
         end
      end
      // shift-jis pairing
      sjis_lead  = (sjis_held >= 8'h81 && sjis_held <= 8'h9F) ||
                   (sjis_held >= 8'hE0 && sjis_held <= 8'hFC);
      sjis_trail = (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
      if (sjis_has_held && sjis_lead && sjis_trail) begin
         if (sjis_pairs != '1)
            sjis_pairs = sjis_pairs + 1'b1;
         sjis_has_held = 1'b0;
      end else begin
         sjis_held     = b;
         sjis_has_held = 1'b1;
      end
      // gbk pairing
      gbk_lead  = (gbk_held >= 8'h81 && gbk_held <= 8'hFE);
      gbk_trail = (b >= 8'h40 && b <= 8'hFE && b != 8'h7F);
      if (gbk_has_held && gbk_lead && gbk_trail) begin
         if (gbk_pairs != '1)
            gbk_pairs = gbk_pairs + 1'b1;
         gbk_has_held = 1'b0;
      end else begin
         gbk_held     = b;
         gbk_has_held = 1'b1;
      end
      if (last) begin
         if (!utf8_broken && owed == 2'd0)
            verdict = tec_pkg::CLASS_UTF8;
         else if (sjis_pairs > gbk_pairs && sjis_pairs != '0)
            verdict = tec_pkg::CLASS_SJIS;
         else if (gbk_pairs != '0)
            verdict = tec_pkg::CLASS_GBK;
         else
            verdict = tec_pkg::CLASS_CP437;
         expected_q.push_back(verdict);
         clear_state();
      end
   endfunction

   function void check_class(input logic [7:0] word);
      tec_pkg::class_type want;
      if (expected_q.size() == 0) begin
         flag($sformatf("unexpected result 0x%02h with no buffer outstanding", word));
      end else begin
         want = expected_q.pop_front();
         if (word[1:0] !== want || word[7:2] !== 6'd0)
            flag($sformatf("class mismatch: expected %s (%0d), got 0x%02h",
                           want.name(), want, word));
      end
   endfunction

endclass

module tb_text_encoding_classifier;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BYTES = 1600;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [1:0] encoding_class, [7:2] zero

   encoding_scoreboard sb;
   logic [7:0]         buffer_q[$];
   int                 bytes_sent = 0;
   int                 quiet_cycles = 0;
   logic               calm = 1'b0;
   logic               timed_out = 1'b0;

   text_encoding_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 21);
   end

   // transfer monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_class(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   task send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      bytes_sent++;
   endtask

   task send_buffer();
      foreach (buffer_q[i])
         send_byte(buffer_q[i], i == buffer_q.size() - 1);
   endtask

   task run_directed();
      buffer_q = '{8'h00};                      send_buffer();
      buffer_q = '{8'hFF};                      send_buffer();
      buffer_q = '{8'h7F};                      send_buffer();
      buffer_q = '{8'h80};                      send_buffer();
      buffer_q = '{8'hC3, 8'hA9};               send_buffer();
      buffer_q = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_buffer();
      // cut-off sequence, equal pair counts
      buffer_q = '{8'hE3, 8'h81};               send_buffer();
      buffer_q = '{8'hA0, 8'hA1, 8'hFD};        send_buffer();
      buffer_q = '{8'h80, 8'h7F};               send_buffer();
      buffer_q = '{8'h82, 8'hA0, 8'h83, 8'h40}; send_buffer();
      buffer_q = '{8'hC3, 8'h28};               send_buffer();
   endtask

   task build_random_buffer();
      int         mode;
      int         chars;
      int         len;
      logic [7:0] trail;
      buffer_q.delete();
      mode  = $urandom_range(0, 99);
      chars = $urandom_range(1, 6);
      if (mode < 40) begin
         for (int c = 0; c < chars; c++) begin
            len = $urandom_range(1, 4);
            case (len)
               1: buffer_q.push_back(8'($urandom_range(0, 127)));
               2: buffer_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
               3: buffer_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
               default: buffer_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            for (int k = 1; k < len; k++)
               buffer_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
         end
         // broken or cut-off utf-8
         if (mode >= 28) begin
            if ($urandom_range(0, 1) == 0) begin
               buffer_q.push_back(8'hE0 | 8'($urandom_range(0, 23)));
               if ($urandom_range(0, 1) == 0)
                  buffer_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end else begin
               buffer_q[$urandom_range(0, buffer_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end
      end else if (mode < 60) begin
         for (int c = 0; c < chars; c++) begin
            if ($urandom_range(0, 4) == 0)
               buffer_q.push_back(8'($urandom_range(0, 127)));
            buffer_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h81, 8'h9F))
                                                           : 8'($urandom_range(8'hE0, 8'hFC)));
            buffer_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h40, 8'h7E))
                                                           : 8'($urandom_range(8'h80, 8'hFC)));
         end
      end else if (mode < 80) begin
         for (int c = 0; c < chars; c++) begin
            if ($urandom_range(0, 4) == 0)
               buffer_q.push_back(8'($urandom_range(0, 255)));
            buffer_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
            trail = 8'($urandom_range(8'h40, 8'hFD));
            if (trail >= 8'h7F)
               trail = trail + 8'd1;
            buffer_q.push_back(trail);
         end
      end else begin
         len = $urandom_range(1, 16);
         for (int k = 0; k < len; k++)
            buffer_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            run_directed();
            while (bytes_sent < RANDOM_BYTES + 23) begin
               calm = (bytes_sent >= 600 && bytes_sent < 900);
               build_random_buffer();
               send_buffer();
            end
            calm = 1'b0;
            req_tvalid <= 1'b0;
            while (sb.pending() != 0)
               @(posedge clock);
            repeat (8) @(posedge clock);
         end
         begin
            wait (quiet_cycles >= STALL_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      disable fork;
      if (!timed_out && sb.errors == 0 && sb.pending() == 0)
         $display("text_encoding_classifier regression: pass");
      else
         $display("text_encoding_classifier regression: fail");
      $finish;
   end

endmodule
